// ===== rtl/cai_pkg.sv =====
package cai_pkg;

    localparam int ANGLE_BITS_DEF        = 16;
    localparam int CORDIC_ITERATIONS_DEF = 16;

    localparam int XY_W   = 24;
    localparam int D_W    = 25;
    localparam int RAD_W  = 25;
    localparam int SQ_W   = 50;
    localparam int STEP_W = 16;
    localparam int NUM_W  = 38;
    localparam int CW     = 36;
    localparam int ZW     = 33;
    localparam int PROD_W = 55;

    localparam logic [21:0] K24            = 22'd2670177;
    localparam logic [29:0] KINV           = 30'd652032874;
    localparam logic [15:0] STEP_RESET     = 16'd256;
    localparam logic        REG_STEP_LENGTH = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SQRT,
        ST_DIV,
        ST_VINIT,
        ST_VRUN,
        ST_LFIN,
        ST_RMUL,
        ST_RINIT,
        ST_RRUN,
        ST_RFIN,
        ST_OUT
    } state_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0: v = 32'h20000000;
            5'd1: v = 32'h12E4051E;
            5'd2: v = 32'h09FB385B;
            5'd3: v = 32'h051111D4;
            5'd4: v = 32'h028B0D43;
            5'd5: v = 32'h0145D7E1;
            5'd6: v = 32'h00A2F61E;
            5'd7: v = 32'h00517C55;
            5'd8: v = 32'h0028BE53;
            5'd9: v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/circular_arc_interpolator_top.sv =====
// Circular arc interpolator for G02/G03 moves. A load transaction (req_type 0) takes start,
// end and centre in signed Q16.8 plus the direction and gives no result; it runs the
// bit-serial square root, for a non-zero radius the bit-serial divider for the angle step,
// and up to two CORDIC vectoring runs. An advance transaction (req_type 1) returns one point
// from the iterative CORDIC rotation, while the end point or the no-arc status skips the
// rotation. Step length is register 0 of the APB port (Q8.8, reset 256). The block takes
// one transaction at a time; a finished result waits in the output register while the next
// transaction is taken.
module circular_arc_interpolator_top
    import cai_pkg::*;
#(
    parameter int ANGLE_BITS        = ANGLE_BITS_DEF,
    parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_req_type,
    input  logic signed [XY_W-1:0]  s_start_x,
    input  logic signed [XY_W-1:0]  s_start_y,
    input  logic signed [XY_W-1:0]  s_end_x,
    input  logic signed [XY_W-1:0]  s_end_y,
    input  logic signed [XY_W-1:0]  s_center_x,
    input  logic signed [XY_W-1:0]  s_center_y,
    input  logic                    s_clockwise,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [XY_W-1:0]  m_point_x,
    output logic signed [XY_W-1:0]  m_point_y,
    output logic                    m_last_point,
    output logic                    m_status
);

    localparam int AW    = ANGLE_BITS + 2;
    localparam int IW    = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;
    localparam int DW    = RAD_W + 24 - ANGLE_BITS;
    localparam int DCW   = $clog2(NUM_W);
    localparam logic [IW-1:0]  IT_LAST = IW'(CORDIC_ITERATIONS - 1);
    localparam logic [DCW-1:0] DIV_LAST = DCW'(NUM_W - 1);
    localparam logic [31:0] RND = 32'd1 << (31 - ANGLE_BITS);
    localparam logic [ANGLE_BITS-1:0] A_Q  = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    localparam logic [ANGLE_BITS-1:0] A_H  = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
    localparam logic [ANGLE_BITS-1:0] A_3Q = A_Q | A_H;
    localparam logic [AW-1:0] TURN = AW'(1) << ANGLE_BITS;
    localparam logic signed [CW-1:0] SAT_MAX = CW'(8388607);
    localparam logic signed [CW-1:0] SAT_MIN = -CW'(8388608);

    state_t state_reg, state_next;

    logic [STEP_W-1:0] step_length_reg;
    logic              arc_active_reg;
    logic              m_valid_reg;

    logic                    cw_reg;
    logic [AW-1:0]           cur_reg, tgt_reg;
    logic [STEP_W-1:0]       astep_reg;
    logic [RAD_W-1:0]        radius_reg;
    logic signed [XY_W-1:0]  ctr_x_reg, ctr_y_reg, end_x_reg, end_y_reg;
    logic signed [D_W-1:0]   dsx_reg, dsy_reg, dex_reg, dey_reg;
    logic [ANGLE_BITS-1:0]   a1_reg, a2_reg;
    logic                    sel_reg;
    logic [SQ_W-1:0]         sq_v_reg, sq_bit_reg;
    logic [SQ_W:0]           sq_r_reg;
    logic [NUM_W-1:0]        quo_reg;
    logic [DW:0]             rem_reg;
    logic [DCW-1:0]          dcnt_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic signed [CW-1:0]    x_reg, y_reg;
    logic [ZW-1:0]           z_reg;
    logic [IW-1:0]           it_reg;
    logic signed [XY_W-1:0]  res_x_reg, res_y_reg;
    logic                    res_last_reg, res_status_reg;
    logic signed [XY_W-1:0]  m_x_reg, m_y_reg;
    logic                    m_last_reg, m_status_reg;

    logic s_fire, slot_free, cfg_wr, more, rot_mode;
    logic [SQ_W:0] sq_trial;
    logic [SQ_W-1:0] sq_bit_next;
    logic [DW:0] rem_sh;
    logic [DW-1:0] dvs;
    logic signed [CW-1:0] x_next, y_next, xs, ys;
    logic [ZW-1:0] z_next, atan_ext;
    logic [31:0] zr;
    logic [ANGLE_BITS-1:0] vang, vaxis;
    logic signed [D_W-1:0] vx, vy;
    logic [31:0] za;
    logic [33:0] mag;
    logic signed [CW-1:0] px, py, sx, sy;
    logic [AW-1:0] diff;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && (paddr[2] == REG_STEP_LENGTH);
    assign prdata    = (paddr[2] == REG_STEP_LENGTH) ? 32'(step_length_reg) : 32'd0;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;
    assign more      = cw_reg ? (cur_reg > tgt_reg) : (cur_reg < tgt_reg);
    assign rot_mode  = (state_reg == ST_RRUN);

    assign m_valid      = m_valid_reg;
    assign m_point_x    = m_x_reg;
    assign m_point_y    = m_y_reg;
    assign m_last_point = m_last_reg;
    assign m_status     = m_status_reg;

    // square root digit
    always_comb begin
        sq_trial    = sq_r_reg + (SQ_W+1)'(sq_bit_reg);
        sq_bit_next = sq_bit_reg >> 2;
    end

    // divider digit
    always_comb begin
        dvs    = DW'(radius_reg) << (24 - ANGLE_BITS);
        rem_sh = {rem_reg[DW-1:0], quo_reg[NUM_W-1]};
    end

    // cordic iteration
    always_comb begin
        xs       = x_reg >>> it_reg;
        ys       = y_reg >>> it_reg;
        atan_ext = ZW'(atan_turn(5'(it_reg)));
        if (rot_mode ? !z_reg[ZW-1] : (!y_reg[CW-1] && (y_reg != '0))) begin
            x_next = rot_mode ? x_reg - ys : x_reg + ys;
            y_next = rot_mode ? y_reg + xs : y_reg - xs;
            z_next = rot_mode ? z_reg - atan_ext : z_reg + atan_ext;
        end else begin
            x_next = rot_mode ? x_reg + ys : x_reg - ys;
            y_next = rot_mode ? y_reg - xs : y_reg + xs;
            z_next = rot_mode ? z_reg + atan_ext : z_reg - atan_ext;
        end
        zr   = z_next[31:0] + RND;
        vang = zr[31 -: ANGLE_BITS];
        vx   = sel_reg ? dex_reg : dsx_reg;
        vy   = sel_reg ? dey_reg : dsy_reg;
        if (vx == '0 && vy == '0) begin
            vaxis = '0;
        end else if (vx == '0) begin
            vaxis = vy[D_W-1] ? A_3Q : A_Q;
        end else begin
            vaxis = vx[D_W-1] ? A_H : '0;
        end
        za   = 32'(cur_reg[ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);
        mag  = 34'((prod_reg + PROD_W'(2097152)) >> 22);
        px   = (x_reg + CW'(128)) >>> 8;
        py   = (y_reg + CW'(128)) >>> 8;
        sx   = px + CW'(ctr_x_reg);
        sy   = py + CW'(ctr_y_reg);
        diff = cw_reg ? cur_reg - tgt_reg : tgt_reg - cur_reg;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (!s_req_type) begin
                        state_next = ST_MUL;
                    end else if (arc_active_reg && more) begin
                        state_next = ST_RMUL;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_MUL:  state_next = ST_SQRT;
            ST_SQRT: begin
                if (sq_bit_reg[0]) begin
                    state_next = (sq_trial <= (SQ_W+1)'(sq_v_reg) || sq_r_reg[RAD_W:1] != '0)
                                 ? ST_DIV : ST_VINIT;
                end
            end
            ST_DIV:  if (dcnt_reg == DIV_LAST) state_next = ST_VINIT;
            ST_VINIT: begin
                if ((vx == '0) || (vy == '0)) begin
                    if (sel_reg) state_next = ST_LFIN;
                end else begin
                    state_next = ST_VRUN;
                end
            end
            ST_VRUN: if (it_reg == IT_LAST) state_next = sel_reg ? ST_LFIN : ST_VINIT;
            ST_LFIN:  state_next = ST_IDLE;
            ST_RMUL:  state_next = ST_RINIT;
            ST_RINIT: state_next = ST_RRUN;
            ST_RRUN:  if (it_reg == IT_LAST) state_next = ST_RFIN;
            ST_RFIN:  state_next = ST_OUT;
            ST_OUT:   if (slot_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            step_length_reg <= STEP_RESET;
            arc_active_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr) step_length_reg <= pwdata[STEP_W-1:0];
            if (s_fire && s_req_type && arc_active_reg && !more) arc_active_reg <= 1'b0;
            if (state_reg == ST_LFIN) arc_active_reg <= 1'b1;
            if (state_reg == ST_OUT && slot_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (!s_req_type) begin
                        dsx_reg   <= D_W'(s_start_x) - D_W'(s_center_x);
                        dsy_reg   <= D_W'(s_start_y) - D_W'(s_center_y);
                        dex_reg   <= D_W'(s_end_x) - D_W'(s_center_x);
                        dey_reg   <= D_W'(s_end_y) - D_W'(s_center_y);
                        ctr_x_reg <= s_center_x;
                        ctr_y_reg <= s_center_y;
                        end_x_reg <= s_end_x;
                        end_y_reg <= s_end_y;
                        cw_reg    <= s_clockwise;
                    end else if (!arc_active_reg) begin
                        res_x_reg      <= '0;
                        res_y_reg      <= '0;
                        res_last_reg   <= 1'b0;
                        res_status_reg <= 1'b1;
                    end else begin
                        res_x_reg      <= end_x_reg;
                        res_y_reg      <= end_y_reg;
                        res_last_reg   <= 1'b1;
                        res_status_reg <= 1'b0;
                    end
                end
            end
            ST_MUL: begin
                sq_v_reg   <= SQ_W'(dsx_reg) * SQ_W'(dsx_reg) + SQ_W'(dsy_reg) * SQ_W'(dsy_reg);
                sq_r_reg   <= '0;
                sq_bit_reg <= SQ_W'(1) << 48;
                quo_reg    <= NUM_W'(step_length_reg) * NUM_W'(K24);
                rem_reg    <= '0;
                dcnt_reg   <= '0;
                sel_reg    <= 1'b0;
            end
            ST_SQRT: begin
                if ((SQ_W+1)'(sq_v_reg) >= sq_trial) begin
                    sq_v_reg <= SQ_W'((SQ_W+1)'(sq_v_reg) - sq_trial);
                    sq_r_reg <= (sq_r_reg >> 1) + (SQ_W+1)'(sq_bit_reg);
                end else begin
                    sq_r_reg <= sq_r_reg >> 1;
                end
                sq_bit_reg <= sq_bit_next;
                if (sq_bit_reg[0]) begin
                    if ((SQ_W+1)'(sq_v_reg) >= sq_trial) begin
                        radius_reg <= RAD_W'((sq_r_reg >> 1) + (SQ_W+1)'(sq_bit_reg));
                    end else begin
                        radius_reg <= RAD_W'(sq_r_reg >> 1);
                    end
                    astep_reg <= 16'hFFFF;
                end
            end
            ST_DIV: begin
                if (rem_sh >= (DW+1)'(dvs)) begin
                    rem_reg <= rem_sh - (DW+1)'(dvs);
                    quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg + 1'b1;
                if (dcnt_reg == DIV_LAST) begin
                    if (rem_sh >= (DW+1)'(dvs)) begin
                        astep_reg <= (quo_reg[NUM_W-2:STEP_W-1] != '0) ? 16'hFFFF
                                     : {quo_reg[STEP_W-2:0], 1'b1};
                    end else if (quo_reg[NUM_W-2:STEP_W-1] != '0) begin
                        astep_reg <= 16'hFFFF;
                    end else if (quo_reg[STEP_W-2:0] == '0) begin
                        astep_reg <= 16'd1;
                    end else begin
                        astep_reg <= {quo_reg[STEP_W-2:0], 1'b0};
                    end
                end
            end
            ST_VINIT: begin
                it_reg <= '0;
                if ((vx == '0) || (vy == '0)) begin
                    if (sel_reg) a2_reg <= vaxis; else a1_reg <= vaxis;
                    sel_reg <= 1'b1;
                end else if (vx[D_W-1]) begin
                    x_reg <= -(CW'(vx) <<< 6);
                    y_reg <= -(CW'(vy) <<< 6);
                    z_reg <= ZW'(32'h80000000);
                end else begin
                    x_reg <= CW'(vx) <<< 6;
                    y_reg <= CW'(vy) <<< 6;
                    z_reg <= '0;
                end
            end
            ST_VRUN: begin
                x_reg  <= x_next;
                y_reg  <= y_next;
                z_reg  <= z_next;
                it_reg <= it_reg + 1'b1;
                if (it_reg == IT_LAST) begin
                    if (sel_reg) a2_reg <= vang; else a1_reg <= vang;
                    sel_reg <= 1'b1;
                end
            end
            ST_LFIN: begin
                if (cw_reg) begin
                    tgt_reg <= AW'(a2_reg);
                    cur_reg <= (a2_reg < a1_reg) ? AW'(a1_reg) : AW'(a1_reg) + TURN;
                end else begin
                    cur_reg <= AW'(a1_reg);
                    tgt_reg <= (a2_reg > a1_reg) ? AW'(a2_reg) : AW'(a2_reg) + TURN;
                end
            end
            ST_RMUL: prod_reg <= PROD_W'(radius_reg) * PROD_W'(KINV);
            ST_RINIT: begin
                it_reg <= '0;
                z_reg  <= ZW'(za[29:0]);
                case (za[31:30])
                    2'd0: begin x_reg <= CW'(mag);  y_reg <= '0; end
                    2'd1: begin x_reg <= '0;        y_reg <= CW'(mag); end
                    2'd2: begin x_reg <= -CW'(mag); y_reg <= '0; end
                    default: begin x_reg <= '0;     y_reg <= -CW'(mag); end
                endcase
            end
            ST_RRUN: begin
                x_reg  <= x_next;
                y_reg  <= y_next;
                z_reg  <= z_next;
                it_reg <= it_reg + 1'b1;
            end
            ST_RFIN: begin
                res_x_reg <= (sx > SAT_MAX) ? XY_W'(SAT_MAX)
                           : (sx < SAT_MIN) ? XY_W'(SAT_MIN) : XY_W'(sx);
                res_y_reg <= (sy > SAT_MAX) ? XY_W'(SAT_MAX)
                           : (sy < SAT_MIN) ? XY_W'(SAT_MIN) : XY_W'(sy);
                res_last_reg   <= 1'b0;
                res_status_reg <= 1'b0;
                if (diff > AW'(astep_reg)) begin
                    cur_reg <= cw_reg ? cur_reg - AW'(astep_reg) : cur_reg + AW'(astep_reg);
                end else begin
                    cur_reg <= tgt_reg;
                end
            end
            ST_OUT: begin
                if (slot_free) begin
                    m_x_reg      <= res_x_reg;
                    m_y_reg      <= res_y_reg;
                    m_last_reg   <= res_last_reg;
                    m_status_reg <= res_status_reg;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import cai_pkg::*;

    typedef struct {
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic               last;
        logic               status;
    } point_t;

    localparam logic [2:0] STEP_ADDR = {REG_STEP_LENGTH, 2'b00};
    localparam int unsigned TURN_UNITS = 32'd65536;
    localparam longint unsigned ANGLE_MASK = 64'h3FFFF;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0, s_ready;
    logic s_req_type = 1'b0, s_clockwise = 1'b0;
    logic signed [23:0] s_start_x = '0, s_start_y = '0, s_end_x = '0, s_end_y = '0;
    logic signed [23:0] s_center_x = '0, s_center_y = '0;
    logic m_valid, m_ready = 1'b0;
    logic signed [23:0] m_point_x, m_point_y;
    logic m_last_point, m_status;

    circular_arc_interpolator_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_start_x(s_start_x), .s_start_y(s_start_y), .s_end_x(s_end_x),
        .s_end_y(s_end_y), .s_center_x(s_center_x), .s_center_y(s_center_y),
        .s_clockwise(s_clockwise),
        .m_valid(m_valid), .m_ready(m_ready), .m_point_x(m_point_x),
        .m_point_y(m_point_y), .m_last_point(m_last_point), .m_status(m_status)
    );

    always #2 aclk = ~aclk;

    // interpolator state mirror
    logic [15:0]    step_len = STEP_RESET;
    bit             arc_on, arc_cw;
    int unsigned    cur_ang, tgt_ang, ang_step, radius;
    longint         ctr_x, ctr_y, end_x, end_y;

    point_t         expected_points[$];
    int             errors = 0;
    int             points_checked = 0;
    int             arcs_loaded = 0;
    int             items_sent = 0;
    int             idle_pct = 0;
    int             stall_pct = 0;
    bit             pred_last;

    int unsigned atan_tab[16] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic int unsigned vector_angle(longint x, longint y);
        logic [31:0] z;
        longint dx, dy;
        longint unsigned t;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x == 0) return (y > 0) ? TURN_UNITS / 4 : (TURN_UNITS / 4) * 3;
        if (y == 0) return (x > 0) ? 0 : TURN_UNITS / 2;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h80000000;
        end
        x = x * 64;
        y = y * 64;
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx; y = y - dy; z = z + atan_tab[i];
            end else begin
                x = x - dx; y = y + dy; z = z - atan_tab[i];
            end
        end
        t = ({32'b0, z} + 64'd32768) >> 16;
        return int'(t & 64'hFFFF);
    endfunction

    function automatic logic signed [23:0] sat24(longint v);
        if (v > 8388607) return 24'sh7FFFFF;
        if (v < -8388608) return 24'sh800000;
        return v[23:0];
    endfunction

    function automatic point_t arc_point(int unsigned a);
        logic [31:0] z;
        longint r, m, x, y, dx, dy;
        point_t p;
        z = (a & 32'hFFFF) << 16;
        r = longint'(z & 32'h3FFFFFFF);
        m = longint'((longint'(radius) * longint'(KINV) + (64'd1 << 21)) >> 22);
        case (z[31:30])
            2'd0: begin x = m; y = 0; end
            2'd1: begin x = 0; y = m; end
            2'd2: begin x = -m; y = 0; end
            default: begin x = 0; y = -m; end
        endcase
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (r >= 0) begin
                x = x - dx; y = y + dy; r = r - atan_tab[i];
            end else begin
                x = x + dx; y = y - dy; r = r + atan_tab[i];
            end
        end
        p.px = sat24(((x + 128) >>> 8) + ctr_x);
        p.py = sat24(((y + 128) >>> 8) + ctr_y);
        p.last = 1'b0;
        p.status = 1'b0;
        return p;
    endfunction

    // advances the mirror by one transaction, returns 1 when a point is due
    function automatic bit predict_arc(bit req, longint sx, longint sy, longint ex,
                                       longint ey, longint cx, longint cy, bit cw,
                                       output point_t p);
        longint dx, dy, fx, fy;
        int unsigned a1, a2;
        longint unsigned q;
        p = '{0, 0, 0, 0};
        if (!req) begin
            dx = sx - cx; dy = sy - cy;
            fx = ex - cx; fy = ey - cy;
            a1 = vector_angle(dx, dy);
            a2 = vector_angle(fx, fy);
            radius = int'(int_sqrt(longint'(dx * dx) + longint'(dy * dy)) & 64'h1FFFFFF);
            if (radius == 0) begin
                q = 64'hFFFF;
            end else begin
                q = ((longint'(step_len) * longint'(K24)) << 16) / (longint'(radius) << 24);
                if (q > 64'hFFFF) q = 64'hFFFF;
            end
            if (q == 0) q = 1;
            ang_step = int'(q);
            arc_cw = cw;
            if (cw) begin
                tgt_ang = a2;
                cur_ang = (a2 < a1) ? a1 : a1 + TURN_UNITS;
            end else begin
                cur_ang = a1;
                tgt_ang = (a2 > a1) ? a2 : a2 + TURN_UNITS;
            end
            cur_ang = cur_ang & ANGLE_MASK;
            tgt_ang = tgt_ang & ANGLE_MASK;
            ctr_x = cx; ctr_y = cy;
            end_x = ex; end_y = ey;
            arc_on = 1;
            return 0;
        end
        if (!arc_on) begin
            p.status = 1'b1;
            return 1;
        end
        if (arc_cw ? (cur_ang > tgt_ang) : (cur_ang < tgt_ang)) begin
            p = arc_point(cur_ang);
            if (arc_cw)
                cur_ang = (cur_ang - tgt_ang > ang_step) ? cur_ang - ang_step : tgt_ang;
            else
                cur_ang = (tgt_ang - cur_ang > ang_step) ? cur_ang + ang_step : tgt_ang;
        end else begin
            p.px = end_x[23:0];
            p.py = end_y[23:0];
            p.last = 1'b1;
            arc_on = 0;
        end
        return 1;
    endfunction

    task automatic send_item(bit req, logic signed [23:0] sx, logic signed [23:0] sy,
                             logic signed [23:0] ex, logic signed [23:0] ey,
                             logic signed [23:0] cx, logic signed [23:0] cy, bit cw);
        point_t p;
        while ($urandom_range(99) < idle_pct) @(negedge aclk);
        s_req_type = req;
        s_start_x = sx; s_start_y = sy;
        s_end_x = ex; s_end_y = ey;
        s_center_x = cx; s_center_y = cy;
        s_clockwise = cw;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        pred_last = 0;
        if (predict_arc(req, sx, sy, ex, ey, cx, cy, cw, p)) begin
            expected_points.push_back(p);
            pred_last = p.last | p.status;
        end
        if (!req) arcs_loaded++;
        items_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic send_advance();
        send_item(1'b1, 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                  24'($urandom), 24'($urandom), 1'($urandom_range(1)));
    endtask

    // load an arc and step through it, up to max_pts advances
    task automatic run_arc(logic signed [23:0] sx, logic signed [23:0] sy,
                           logic signed [23:0] ex, logic signed [23:0] ey,
                           logic signed [23:0] cx, logic signed [23:0] cy,
                           bit cw, int max_pts);
        send_item(1'b0, sx, sy, ex, ey, cx, cy, cw);
        for (int n = 0; n < max_pts; n++) begin
            send_advance();
            if (pred_last) break;
        end
    endtask

    task automatic random_arc(int max_pts);
        longint cx, cy, r;
        int sel;
        sel = $urandom_range(99);
        cx = $signed(24'($urandom));
        cy = $signed(24'($urandom));
        if (sel < 70) r = $urandom_range(1500);
        else if (sel < 90) r = $urandom_range(40000);
        else r = $urandom_range(8388607);
        if (sel > 96) begin
            run_arc(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                    24'($urandom), 24'($urandom), 1'($urandom_range(1)), max_pts);
        end else begin
            run_arc(24'(cx + $signed($urandom_range(2 * r)) - r),
                    24'(cy + $signed($urandom_range(2 * r)) - r),
                    24'(cx + $signed($urandom_range(2 * r)) - r),
                    24'(cy + $signed($urandom_range(2 * r)) - r),
                    24'(cx), 24'(cy), 1'($urandom_range(1)), max_pts);
        end
    endtask

    task automatic wait_idle();
        while (expected_points.size() != 0) @(negedge aclk);
        repeat (150) @(negedge aclk);
    endtask

    task automatic write_step_length(logic [15:0] val);
        wait_idle();
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = STEP_ADDR; pwdata = {16'b0, val};
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        pwrite = 1'b0; penable = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[15:0] !== val) begin
            $display("%0t step_length readback expected %0d actual %0d", $time, val,
                     prdata[15:0]);
            errors++;
        end
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0;
        step_len = val;
    endtask

    task automatic check_field(string name, longint expv, longint actv);
        if (expv != actv) begin
            $display("%0t %s mismatch expected %0d actual %0d", $time, name, expv, actv);
            errors++;
        end
    endtask

    always @(negedge aclk) m_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge aclk) begin
        point_t p;
        if (aresetn && m_valid && m_ready) begin
            if (expected_points.size() == 0) begin
                $display("%0t unexpected transaction x %0d y %0d", $time, m_point_x,
                         m_point_y);
                errors++;
            end else begin
                p = expected_points.pop_front();
                check_field("point_x", p.px, m_point_x);
                check_field("point_y", p.py, m_point_y);
                check_field("last_point", p.last, m_last_point);
                check_field("status", p.status, m_status);
                points_checked++;
            end
        end
    end

    task automatic test_directed();
        send_advance();
        run_arc(24'sd256, 24'sd0, 24'sd0, 24'sd256, 24'sd0, 24'sd0, 1'b0, 40);
        run_arc(24'sd256, 24'sd0, 24'sd0, 24'sd256, 24'sd0, 24'sd0, 1'b1, 40);
        run_arc(-24'sd200, 24'sd50, -24'sd200, 24'sd50, 24'sd10, 24'sd10, 1'b0, 10);
        run_arc(24'sd77, -24'sd5, 24'sd300, 24'sd300, 24'sd77, -24'sd5, 1'b1, 3);
        run_arc(24'sd500, 24'sd500, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0, 2);
        run_arc(24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF,
                24'sh800000, 24'sh800000, 1'b1, 4);
        send_advance();
    endtask

    task automatic test_step_length();
        write_step_length(16'd1);
        run_arc(24'sd3000, 24'sd0, 24'sd0, -24'sd3000, 24'sd0, 24'sd0, 1'b0, 6);
        run_arc(24'sh7FFFFF, 24'sd0, 24'sd0, 24'sh7FFFFF, 24'sh800000, 24'sd0, 1'b0, 3);
        write_step_length(16'd65535);
        run_arc(24'sd40, 24'sd40, 24'sd0, 24'sd40, 24'sd0, 24'sd0, 1'b1, 10);
        run_arc(24'sd90000, 24'sd0, 24'sd90000, 24'sd0, 24'sd0, 24'sd0, 1'b0, 10);
        write_step_length(STEP_RESET);
    endtask

    task automatic test_random();
        int pct[4][2] = '{'{0, 0}, '{50, 0}, '{0, 50}, '{9, 9}};
        logic [15:0] steps[4] = '{16'd256, 16'd1000, 16'd100, 16'd65535};
        for (int ph = 0; ph < 4; ph++) begin
            write_step_length(ph == 3 ? steps[ph] : 16'($urandom_range(60, 2000)));
            idle_pct = pct[ph][0];
            stall_pct = pct[ph][1];
            for (int base = items_sent; items_sent < base + 100; ) begin
                if ($urandom_range(19) == 0) send_advance();
                else random_arc($urandom_range(1, 30));
            end
        end
        idle_pct = 0;
        stall_pct = 0;
    endtask

    initial begin
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_step_length();
        test_random();
        while (expected_points.size() != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
        $display("checked %0d points over %0d arcs, %0d transactions sent",
                 points_checked, arcs_loaded, items_sent);
        $display("step lengths 1 to 65535, idle and stall phases on both channels");
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #8ms;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== circular_arc_interpolator_top.f =====
rtl/cai_pkg.sv
rtl/circular_arc_interpolator_top.sv
tb/sv/testbench.sv
